FILE: sv/adt_pkg.sv
package adt_pkg;

  localparam int BUF_BYTES = 16;
  localparam int COUNT_MAX = 31;

  localparam logic [7:0] TY_BULB  = 8'h75;
  localparam logic [7:0] TY_IOTH  = 8'h77;
  localparam logic [7:0] TY_BLIND = 8'h78;
  localparam logic [7:0] TY_THI   = 8'h69;
  localparam logic [7:0] TY_THT   = 8'h54;
  localparam logic [7:0] TY_BOT   = 8'h48;
  localparam logic [7:0] TY_CURT  = 8'h63;
  localparam logic [7:0] TY_CURT3 = 8'h7B;
  localparam logic [7:0] TY_PRES  = 8'h73;
  localparam logic [7:0] TY_CONT  = 8'h64;
  localparam logic [7:0] TY_REM   = 8'h62;

  typedef enum logic [2:0] {
    OUT_INVALID   = 3'd0,
    OUT_UNCHANGED = 3'd1,
    OUT_UPDATED   = 3'd2,
    OUT_ADDED     = 3'd3,
    OUT_FULL      = 3'd4,
    OUT_CLEARED   = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_COMPARE,
    ST_WRITE,
    ST_REPORT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic buf_write;    // buffer one byte
    logic latch_item;   // capture address/rssi at last byte
    logic clear_marks;
    logic scan_reset;   // start the table search
    logic scan_advance;
    logic fetch;        // read the entry at the scan index
    logic store;        // write buffers into the selected entry
    logic adding;
    logic finish;       // drop counts unless clearing, load the result registers
    outcome_t outcome;
  } adt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic valid_ad;
    logic scan_done;
    logic addr_hit;
    logic same;
    logic full;
  } adt_status_t;

  function automatic logic is_maker_type(input logic [7:0] t);
    return t == TY_BULB || t == TY_IOTH || t == TY_BLIND;
  endfunction

endpackage

FILE: sv/adt_datapath.sv
module adt_datapath #(
  parameter int TABLE_DEPTH   = 64,
  parameter int PAYLOAD_BYTES = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  adt_pkg::adt_cmd_t    cmd,
  output adt_pkg::adt_status_t status,
  input  logic [47:0]          device_address,
  input  logic signed [7:0]    signal_strength,
  input  logic                 section,
  input  logic [7:0]           data_byte,
  output logic                 strobe,
  output logic [2:0]           outcome,
  output logic [5:0]           slot,
  output logic                 any_change_pending,
  output logic [6:0]           slots_used
);
  import adt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [7:0] service_buffer [BUF_BYTES];
  logic [7:0] maker_buffer [BUF_BYTES];
  logic [4:0] service_count, maker_count;

  logic [47:0] item_addr;
  logic [7:0]  item_rssi;

  // table memories
  logic [47:0] slot_address [TABLE_DEPTH];
  logic [8*PAYLOAD_BYTES-1:0] slot_payload [TABLE_DEPTH];
  logic [3:0]  slot_length [TABLE_DEPTH];
  logic [7:0]  slot_rssi [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] slot_dirty;
  logic [CW-1:0] slots_filled;
  logic          global_dirty;

  logic [CW-1:0] scan;
  logic [IW-1:0] sel;
  logic [47:0]   rd_addr;
  logic [8*PAYLOAD_BYTES-1:0] rd_pay;
  logic [3:0]    rd_len;

  logic [7:0] svc [BUF_BYTES];
  logic [7:0] mkr [BUF_BYTES];
  logic [7:0] ty;

  logic ad_ok;
  logic entry_same;

  always_comb begin
    for (int i = 0; i < BUF_BYTES; i++) begin
      svc[i] = (5'(i) < service_count) ? service_buffer[i] : 8'h00;
      mkr[i] = (5'(i) < maker_count) ? maker_buffer[i] : 8'h00;
    end
  end
  assign ty = svc[0];

  function automatic logic [7:0] pb(input logic [8*PAYLOAD_BYTES-1:0] p, input int i);
    return p[8*i +: 8];
  endfunction

  always_comb begin
    logic ok;
    unique case (ty)
      TY_BULB:  ok = maker_count == 5'd13;
      TY_IOTH:  ok = maker_count == 5'd14;
      TY_BLIND: ok = maker_count == 5'd11 || maker_count == 5'd13;
      TY_THI, TY_THT, TY_CURT, TY_CURT3, TY_PRES: ok = service_count == 5'd6;
      TY_BOT:   ok = service_count == 5'd3;
      TY_CONT:  ok = service_count == 5'd9;
      TY_REM:   ok = service_count == 5'd4;
      default:  ok = 1'b0;
    endcase
    ad_ok = ok && service_count != 5'd0;
  end

  assign status = '{
    valid_ad:  ad_ok,
    scan_done: scan >= slots_filled,
    addr_hit:  rd_addr == item_addr,
    same:      entry_same,
    full:      slots_filled >= CW'(TABLE_DEPTH)
  };

  always_comb begin
    logic lenok, eq;
    if (is_maker_type(ty)) lenok = {1'b0, maker_count} == {2'b0, rd_len} - 6'd1;
    else                   lenok = {1'b0, service_count} == {2'b0, rd_len};
    eq = 1'b1;
    case (ty)
      TY_PRES: eq = svc[1] == pb(rd_pay, 1) && svc[2] == pb(rd_pay, 2)
                 && svc[5] == pb(rd_pay, 5);
      TY_CONT: eq = svc[1] == pb(rd_pay, 1) && svc[2] == pb(rd_pay, 2)
                 && svc[3] == pb(rd_pay, 3) && svc[8] == pb(rd_pay, 8);
      TY_BULB: eq = mkr[8] == pb(rd_pay, 9) && mkr[9] == pb(rd_pay, 10)
                 && mkr[10] == pb(rd_pay, 11);
      TY_IOTH: eq = svc[2] == pb(rd_pay, 2) && mkr[10] == pb(rd_pay, 11)
                 && mkr[11] == pb(rd_pay, 12) && mkr[12] == pb(rd_pay, 13);
      TY_BLIND: eq = svc[2] == pb(rd_pay, 2) && mkr[10] == pb(rd_pay, 11);
      default: begin
        for (int i = 0; i < PAYLOAD_BYTES; i++)
          if (4'(i) < rd_len && pb(rd_pay, i) != svc[i]) eq = 1'b0;
      end
    endcase
    entry_same = lenok && eq;
  end

  // new payload image for a store
  logic [8*PAYLOAD_BYTES-1:0] wr_pay;
  logic [3:0] wr_len;
  always_comb begin
    wr_pay = rd_pay;
    if (is_maker_type(ty)) begin
      for (int i = 0; i + 1 < PAYLOAD_BYTES; i++)
        if (5'(i) < maker_count && i < BUF_BYTES) wr_pay[8*(i+1) +: 8] = mkr[i];
      if (cmd.adding) wr_pay[7:0] = ty;
      if (!cmd.adding || ty != TY_BULB) wr_pay[23:16] = svc[2];
      wr_len = 4'(maker_count + 5'd1);
    end else begin
      for (int i = 0; i < PAYLOAD_BYTES; i++)
        if (5'(i) < service_count) wr_pay[8*i +: 8] = svc[i];
      wr_len = service_count[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_write) begin
      if (section) begin
        if (maker_count < 5'(BUF_BYTES)) maker_buffer[maker_count[3:0]] <= data_byte;
      end else begin
        if (service_count < 5'(BUF_BYTES)) service_buffer[service_count[3:0]] <= data_byte;
      end
    end
    if (cmd.latch_item) begin
      item_addr <= device_address;
      item_rssi <= signal_strength;
    end
    if (cmd.fetch) begin
      rd_addr <= slot_address[scan[IW-1:0]];
      rd_pay  <= slot_payload[scan[IW-1:0]];
      rd_len  <= slot_length[scan[IW-1:0]];
      sel     <= scan[IW-1:0];
    end
    if (cmd.store) begin
      slot_address[sel] <= item_addr;
      slot_payload[sel] <= wr_pay;
      slot_length[sel]  <= wr_len;
      slot_rssi[sel]    <= item_rssi;
    end
    if (cmd.finish) begin
      outcome <= cmd.outcome;
      slot <= (cmd.outcome == OUT_UNCHANGED || cmd.outcome == OUT_UPDATED
               || cmd.outcome == OUT_ADDED) ? 6'(sel) : 6'd0;
    end
  end

  logic [CW-1:0] filled_next;
  logic          dirty_next;
  always_comb begin
    filled_next = slots_filled;
    dirty_next  = global_dirty;
    if (cmd.store) begin
      dirty_next = 1'b1;
      if (cmd.adding) filled_next = slots_filled + CW'(1);
    end
    if (cmd.clear_marks) dirty_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      service_count <= '0;
      maker_count   <= '0;
      slot_dirty    <= '0;
      slots_filled  <= '0;
      global_dirty  <= 1'b0;
      scan          <= '0;
      strobe        <= 1'b0;
    end else begin
      strobe <= cmd.finish;
      if (cmd.buf_write) begin
        if (section) begin
          if (maker_count != 5'(COUNT_MAX)) maker_count <= maker_count + 5'd1;
        end else begin
          if (service_count != 5'(COUNT_MAX)) service_count <= service_count + 5'd1;
        end
      end
      if (cmd.finish && cmd.outcome != OUT_CLEARED) begin
        service_count <= '0;
        maker_count   <= '0;
      end
      if (cmd.scan_reset) scan <= '0;
      else if (cmd.scan_advance) scan <= scan + CW'(1);
      if (cmd.clear_marks) slot_dirty <= '0;
      if (cmd.store) slot_dirty[sel] <= 1'b1;
      slots_filled <= filled_next;
      global_dirty <= dirty_next;
    end
  end

  // result registers load together with finish
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      any_change_pending <= dirty_next;
      slots_used         <= 7'(filled_next);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> global_dirty)
    else $error("store left global mark low");
  assert property (@(posedge clk) disable iff (rst)
    slots_filled <= CW'(TABLE_DEPTH))
    else $error("fill count past depth");
  assert property (@(posedge clk) disable iff (rst)
    cmd.clear_marks |=> !global_dirty && slot_dirty == '0)
    else $error("marks not cleared");

endmodule

FILE: sv/adt_control.sv
module adt_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 command,
  input  logic                 last_byte,
  output logic                 busy,
  output adt_pkg::adt_cmd_t    cmd,
  input  adt_pkg::adt_status_t status
);
  import adt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.outcome = OUT_INVALID;
    busy = state != ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (command) begin
            cmd.clear_marks = 1'b1;
            cmd.finish = 1'b1;
            cmd.outcome = OUT_CLEARED;
          end else begin
            cmd.buf_write = 1'b1;
            if (last_byte) begin
              cmd.latch_item = 1'b1;
              cmd.scan_reset = 1'b1;
              state_next = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (!status.valid_ad) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (status.scan_done) begin
          if (status.full) begin
            cmd.finish = 1'b1;
            cmd.outcome = OUT_FULL;
            state_next = ST_IDLE;
          end else begin
            cmd.fetch = 1'b1;
            state_next = ST_WRITE;
          end
        end else begin
          cmd.fetch = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        // each entry: fetched in ST_SEARCH, then its address compared here
        if (status.addr_hit) state_next = ST_COMPARE;
        else begin
          cmd.scan_advance = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_COMPARE: begin
        if (status.same) begin
          cmd.finish = 1'b1;
          cmd.outcome = OUT_UNCHANGED;
          state_next = ST_IDLE;
        end else begin
          cmd.store = 1'b1;
          state_next = ST_REPORT;
        end
      end
      ST_WRITE: begin
        cmd.store = 1'b1;
        cmd.adding = 1'b1;
        cmd.finish = 1'b1;
        cmd.outcome = OUT_ADDED;
        state_next = ST_IDLE;
      end
      ST_REPORT: begin
        cmd.finish = 1'b1;
        cmd.outcome = OUT_UPDATED;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> state == ST_COMPARE || state == ST_WRITE)
    else $error("store outside write states");
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == ST_IDLE)
    else $error("finish did not return to idle");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_REPORT |-> $past(state) == ST_COMPARE)
    else $error("report without compare");

endmodule

FILE: sv/advert_device_table.sv
// Device table fed by radio advertisements, one byte per transaction.
// Input: pulse start with busy low to hand in one byte (command=0) or a
// clear of all change marks (command=1). Bytes of the service or maker
// section are buffered (16 each, extras dropped) at one per cycle while busy
// is low, with no wait. The byte with last_byte set, sampled with
// device_address and signal_strength, starts processing: busy rises while the
// table is searched. Search: the type check is made in the first search state;
// each stored entry visited takes a memory read, then an address compare. An
// add then checks the end of the table and writes; an update compares and
// writes back; an unchanged entry ends after its compare. An invalid
// advertisement ends at the type check, a full table once every stored entry
// is visited. The result strobes in the same cycle that busy falls.
// A clear command gives its result in the next cycle without raising busy.
// Output: one result per last byte or clear, shown for one cycle with
// strobe high; the receiver cannot stall and must take it then.
// Reset: table empty, marks cleared, byte counts zero; stored entries keep
// no contents until written.
module advert_device_table #(
  parameter int TABLE_DEPTH   = 64,
  parameter int PAYLOAD_BYTES = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [47:0]        device_address,
  input  logic signed [7:0]  signal_strength,
  input  logic               section,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               strobe,
  output logic [2:0]         outcome,
  output logic [5:0]         slot,
  output logic               any_change_pending,
  output logic [6:0]         slots_used
);
  import adt_pkg::*;

  adt_cmd_t    cmd;
  adt_status_t status;

  adt_control u_ctrl (
    .clk, .rst, .start, .command, .last_byte, .busy, .cmd, .status
  );

  adt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH), .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_dp (
    .clk, .rst, .cmd, .status, .device_address, .signal_strength, .section,
    .data_byte, .strobe, .outcome, .slot, .any_change_pending, .slots_used
  );

endmodule
